// ===== rtl/core/text_mode_terminal_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker of the text mode terminal engine.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_ENGINE_UNIT_ASSERT_SVH
`define TEXT_MODE_TERMINAL_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TMTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmte: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TMTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmte: next-cycle check failed");

`endif

// ===== rtl/core/tmte_pkg.sv =====
// ----------------------------------------------------------------------------
// tmte_pkg
// Shared types and constants of the text mode terminal engine.
// ----------------------------------------------------------------------------
package tmte_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;
    localparam int OUT_ROW_W   = 5;
    localparam int OUT_COL_W   = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]        NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd2;
    localparam logic [CELL_W-1:0] BLANK_RESET  = 16'd544;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CELL = 1'b1;

    typedef enum logic [2:0] {
        OP_PUT       = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_CLR_LINE  = 3'd2,
        OP_CLR_ALL   = 3'd3,
        OP_READ      = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
        logic [CELL_W-1:0]    cell_value;
    } t_out;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attribute;
        logic [CELL_W-1:0] blank_cell;
    } t_cfg;

endpackage

// ===== rtl/core/tmte_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tmte_cell_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmte_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tmte_pkg::CELL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tmte_pkg::CELL_W-1:0] o_rdata
);
    import tmte_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tmte_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmte_ctrl
// Cursor state, row rotation and the operation sequencer of the terminal.
// ----------------------------------------------------------------------------
module tmte_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  tmte_pkg::t_in               i_in,
    input  tmte_pkg::t_cfg              i_cfg,
    output logic                        o_busy,
    output logic                        o_done,
    output tmte_pkg::t_out              o_out,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [tmte_pkg::CELL_W-1:0] o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [tmte_pkg::CELL_W-1:0] i_mem_rdata
);
    import tmte_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);

    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(ROWS * COLUMNS - 1);
    localparam logic [AW-1:0] COL_COUNT = AW'(COLUMNS);
    localparam logic [AW-1:0] COL_SPAN  = AW'(COLUMNS - 1);
    localparam logic [RW:0]   ROW_COUNT = (RW + 1)'(ROWS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_PUT,
        S_BS_RD,
        S_BS_CHK,
        S_RD_WAIT
    } t_state;

    t_state        r_state;
    t_in           r_in;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_base;
    logic [AW-1:0] r_faddr;
    logic [AW-1:0] r_flast;
    logic          r_put_after;
    logic          r_done;
    t_out          r_out;

    logic          rd_sel;
    logic          rd_in_range;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;
    logic [AW-1:0] row_addr;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] cell_addr;
    logic [RW-1:0] base_inc;
    logic [RW-1:0] bs_row;
    logic [CW-1:0] bs_col;
    logic          origin;
    logic          is_nl;
    logic          plain_put;
    logic          bs_hit;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_inc;

    function automatic t_out make_out(input logic [RW-1:0] row, input logic [CW-1:0] col,
                                      input logic [CELL_W-1:0] cell_val);
        t_out res;
        res.cursor_row = OUT_ROW_W'(row);
        res.cursor_col = OUT_COL_W'(col);
        res.cell_value = cell_val;
        return res;
    endfunction

    // Logical row to physical row through the rotation offset, then cell address.
    always_comb begin
        rd_sel      = (r_state == S_EXEC) && (r_in.op == OP_READ);
        rd_in_range = (32'(r_in.read_row) < ROWS) && (32'(r_in.read_col) < COLUMNS);
        sel_row     = rd_sel ? RW'(r_in.read_row) : r_row;
        sel_col     = rd_sel ? CW'(r_in.read_col) : r_col;
        row_sum     = {1'b0, sel_row} + {1'b0, r_base};
        phys_row    = (row_sum >= ROW_COUNT) ? RW'(row_sum - ROW_COUNT) : RW'(row_sum);
        row_addr    = AW'(phys_row) * COL_COUNT;
        base_addr   = AW'(r_base) * COL_COUNT;
        cell_addr   = row_addr + AW'(sel_col);
        base_inc    = (r_base == ROW_LAST) ? '0 : RW'(r_base + 1'b1);
        origin      = (r_row == '0) && (r_col == '0);
        bs_row      = (r_col == '0) ? RW'(r_row - 1'b1) : r_row;
        bs_col      = (r_col == '0) ? COL_LAST : CW'(r_col - 1'b1);
        col_inc     = CW'(r_col + 1'b1);
        row_inc     = RW'(r_row + 1'b1);
        is_nl       = (r_in.char_code == NEWLINE_CODE);
        plain_put   = !is_nl && (r_col != COL_END);
        bs_hit      = (i_mem_rdata != i_cfg.blank_cell) || origin;
    end

    always_comb begin
        o_mem_we    = (r_state == S_INIT) || (r_state == S_FILL) || (r_state == S_PUT)
                   || ((r_state == S_EXEC) && (r_in.op == OP_PUT) && plain_put)
                   || ((r_state == S_BS_CHK) && bs_hit);
        o_mem_waddr = ((r_state == S_INIT) || (r_state == S_FILL)) ? r_faddr : cell_addr;
        if (r_state == S_INIT) begin
            o_mem_wdata = BLANK_RESET;
        end else if ((r_state == S_FILL) || (r_state == S_BS_CHK)) begin
            o_mem_wdata = i_cfg.blank_cell;
        end else begin
            o_mem_wdata = {i_cfg.text_attribute, r_in.char_code};
        end
        o_mem_re    = (rd_sel && rd_in_range) || (r_state == S_BS_RD);
        o_mem_raddr = cell_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_faddr     <= '0;
            r_flast     <= CELL_LAST;
            r_put_after <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_faddr <= AW'(r_faddr + 1'b1);
                    if (r_faddr == CELL_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_in    <= i_in;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_in.op)
                        OP_PUT: begin
                            if (plain_put) begin
                                r_col   <= col_inc;
                                r_done  <= 1'b1;
                                r_out   <= make_out(r_row, col_inc, '0);
                                r_state <= S_IDLE;
                            end else begin
                                r_col       <= '0;
                                r_put_after <= !is_nl;
                                if (r_row == ROW_LAST) begin
                                    // Scroll: rotate rows, blank the old top row.
                                    r_base  <= base_inc;
                                    r_faddr <= base_addr;
                                    r_flast <= base_addr + COL_SPAN;
                                    r_state <= S_FILL;
                                end else if (is_nl) begin
                                    r_row   <= row_inc;
                                    r_done  <= 1'b1;
                                    r_out   <= make_out(row_inc, '0, '0);
                                    r_state <= S_IDLE;
                                end else begin
                                    r_row   <= row_inc;
                                    r_state <= S_PUT;
                                end
                            end
                        end
                        OP_BACKSPACE: begin
                            if (origin) begin
                                r_done  <= 1'b1;
                                r_out   <= make_out(r_row, r_col, '0);
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= bs_row;
                                r_col   <= bs_col;
                                r_state <= S_BS_RD;
                            end
                        end
                        OP_CLR_LINE: begin
                            r_col       <= '0;
                            r_faddr     <= row_addr;
                            r_flast     <= row_addr + COL_SPAN;
                            r_put_after <= 1'b0;
                            r_state     <= S_FILL;
                        end
                        OP_CLR_ALL: begin
                            r_row       <= '0;
                            r_col       <= '0;
                            r_base      <= '0;
                            r_faddr     <= '0;
                            r_flast     <= CELL_LAST;
                            r_put_after <= 1'b0;
                            r_state     <= S_FILL;
                        end
                        OP_READ: begin
                            if (rd_in_range) begin
                                r_state <= S_RD_WAIT;
                            end else begin
                                r_done  <= 1'b1;
                                r_out   <= make_out(r_row, r_col, '0);
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_out   <= make_out(r_row, r_col, '0);
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_FILL: begin
                    r_faddr <= AW'(r_faddr + 1'b1);
                    if (r_faddr == r_flast) begin
                        if (r_put_after) begin
                            r_state <= S_PUT;
                        end else begin
                            r_done  <= 1'b1;
                            r_out   <= make_out(r_row, r_col, '0);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PUT: begin
                    r_col   <= col_inc;
                    r_done  <= 1'b1;
                    r_out   <= make_out(r_row, col_inc, '0);
                    r_state <= S_IDLE;
                end
                S_BS_RD: begin
                    r_state <= S_BS_CHK;
                end
                S_BS_CHK: begin
                    if (bs_hit) begin
                        r_done  <= 1'b1;
                        r_out   <= make_out(r_row, r_col, '0);
                        r_state <= S_IDLE;
                    end else begin
                        r_row   <= bs_row;
                        r_col   <= bs_col;
                        r_state <= S_BS_RD;
                    end
                end
                S_RD_WAIT: begin
                    r_done  <= 1'b1;
                    r_out   <= make_out(r_row, r_col, i_mem_rdata);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// ===== rtl/core/text_mode_terminal_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_engine_unit
// Text screen of ROWS by COLUMNS attribute/character cells with a cursor.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where i_start is high and o_busy is low,
// and its single result beat appears on o_out for exactly one cycle with
// o_done high; the receiver cannot stall it, so it must capture the beat in
// that cycle. Results come back in command order. The single write port of
// the cell memory blanks one cell per cycle in clears and scrolls, and
// reads and the backspace walk wait for its registered read data. A new
// command may be started in the cycle that shows the previous result.
// Scrolling does not move cells: the rows rotate through a base pointer and
// only the recycled row is blanked. After reset the block runs a clearing
// pass over all ROWS * COLUMNS cells (2000 at the default size) with o_busy
// high. The user is to make configuration writes only during it or while
// the block is idle, which the block itself does not enforce; writes taken
// then apply to the commands that follow.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine_unit #(
    parameter int COLUMNS = tmte_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmte_pkg::ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  tmte_pkg::t_in                   i_in,
    output logic                            o_done,
    output tmte_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [tmte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tmte_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tmte_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    // Configuration registers; the write data is as wide as the blank cell.
    logic [ATTR_W-1:0] r_attr;
    logic [CELL_W-1:0] r_blank;
    t_cfg              cfg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= ATTR_RESET;
            r_blank <= BLANK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEXT_ATTR:  r_attr  <= i_cfg_wdata[ATTR_W-1:0];
                CFG_BLANK_CELL: r_blank <= i_cfg_wdata[CELL_W-1:0];
                default:        r_attr  <= r_attr;
            endcase
        end
    end

    assign cfg.text_attribute = r_attr;
    assign cfg.blank_cell     = r_blank;

    // The sequencer owns the cursor and the row rotation; all reads of the
    // screen are issued by it and no read overlaps a write of the same
    // command, so the memory needs no forwarding path.
    tmte_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tmte_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== rtl/core/tmte_checker.sv =====
// ----------------------------------------------------------------------------
// tmte_checker
// Port-level checks of the terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_mode_terminal_engine_unit_assert.svh"

module tmte_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_start,
    input logic                            o_busy,
    input tmte_pkg::t_in                   i_in,
    input logic                            o_done,
    input tmte_pkg::t_out                  o_out,
    input logic                            i_cfg_we,
    input logic [tmte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [tmte_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tmte_pkg::*;

    // An accepted command makes the block busy in the following cycle.
    `TMTE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // The result beat coincides with the return to idle.
    `TMTE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    // A result beat closes a command that was in progress in the cycle before.
    `TMTE_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, o_done, $past(o_busy))
    // A command taken at a beat still passes through the execute state, so beats never run back to back.
    `TMTE_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

endmodule

bind text_mode_terminal_engine_unit tmte_checker u_tmte_checker (.*);

// ===== bench/tmte_screen_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmte_screen_checker
// Watches the command, result and register ports of the text terminal engine.
// It keeps its own copy of the screen, the cursor and the two registers. For
// every accepted command it works out the cursor report and the read value.
// It then compares each result beat with the oldest outstanding report.
// ----------------------------------------------------------------------------
module tmte_screen_checker
    import tmte_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in                   i_in,
    input  logic                  i_done,
    input  t_out                  i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_beats_checked
);

    logic [CELL_W-1:0] screen [0:ROWS*COLUMNS-1];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] text_attr;
    logic [CELL_W-1:0] blank_value;
    t_out              cursor_reports [$];

    function automatic void blank_row(int r);
        for (int x = 0; x < COLUMNS; x++) begin
            screen[r*COLUMNS + x] = blank_value;
        end
    endfunction

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++) begin
            blank_row(r);
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    // The screen scrolls up when the cursor leaves the bottom row.
    function automatic void next_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < COLUMNS*(ROWS-1); i++) begin
                screen[i] = screen[i + COLUMNS];
            end
            blank_row(ROWS-1);
            cur_row = ROWS-1;
        end
    endfunction

    function automatic void put_char(logic [7:0] ch);
        if (ch == NEWLINE_CODE) begin
            next_row();
        end else begin
            if (cur_col >= COLUMNS) begin
                next_row();
            end
            screen[cur_row*COLUMNS + cur_col] = {text_attr, ch};
            cur_col++;
        end
    endfunction

    // Walk back over blank cells, stop on the first non-blank one or at the
    // origin, and blank whatever cell the cursor ends on.
    function automatic void back_space();
        if (cur_row == 0 && cur_col == 0) begin
            return;
        end
        forever begin
            if (cur_col == 0) begin
                cur_row--;
                cur_col = COLUMNS-1;
            end else begin
                cur_col--;
            end
            if (screen[cur_row*COLUMNS + cur_col] != blank_value) begin
                break;
            end
            if (cur_row == 0 && cur_col == 0) begin
                break;
            end
        end
        screen[cur_row*COLUMNS + cur_col] = blank_value;
    endfunction

    function automatic t_out apply_command(t_in cmd);
        t_out report;
        report.cell_value = '0;
        case (cmd.op)
            OP_PUT:       put_char(cmd.char_code);
            OP_BACKSPACE: back_space();
            OP_CLR_LINE: begin
                blank_row(cur_row);
                cur_col = 0;
            end
            OP_CLR_ALL:   blank_screen();
            OP_READ: begin
                if (cmd.read_row < ROWS && cmd.read_col < COLUMNS) begin
                    report.cell_value = screen[cmd.read_row*COLUMNS + cmd.read_col];
                end
            end
            default: ;
        endcase
        report.cursor_row = OUT_ROW_W'(cur_row);
        report.cursor_col = OUT_COL_W'(cur_col);
        return report;
    endfunction

    function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                        logic [CELL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            text_attr   = ATTR_RESET;
            blank_value = BLANK_RESET;
            blank_screen();
            cursor_reports.delete();
        end else begin
            // A result beat and the next command can share an edge; the beat
            // always belongs to an earlier command, so it is matched first.
            if (i_done) begin
                if (cursor_reports.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = cursor_reports.pop_front();
                    check_field("cursor_row", CELL_W'(want.cursor_row),
                                CELL_W'(i_out.cursor_row));
                    check_field("cursor_col", CELL_W'(want.cursor_col),
                                CELL_W'(i_out.cursor_col));
                    check_field("cell_value", want.cell_value, i_out.cell_value);
                    o_beats_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEXT_ATTR:  text_attr   = i_cfg_wdata[ATTR_W-1:0];
                    CFG_BLANK_CELL: blank_value = i_cfg_wdata[CELL_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                cursor_reports.push_back(apply_command(i_in));
            end
        end
        o_pending = cursor_reports.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Command stimulus and verdict for the text mode terminal engine.
// A short directed run covers the field extremes and the corner cases. Six
// random phases follow, each with its own register setting and sender idle
// rate. The random phases favor lines of text, newline bursts, backspace
// bursts and cell reads, so wraps, scrolls and backspace walks are reached.
// Checking is done by the screen checker that sits beside the engine.
// ----------------------------------------------------------------------------
module tb_top;
    import tmte_pkg::*;

    localparam int COLUMNS         = COLUMNS_DEF;
    localparam int ROWS            = ROWS_DEF;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 300;
    // A full backspace walk over the whole screen is the slowest command
    // there is. Even if every command took that long, with idle gaps on
    // top, the run would stay several times below this.
    localparam int CYCLE_LIMIT     = 40_000_000;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_X     = 8'h78;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_in                   i_in        = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_TEXT_ATTR;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_busy;
    logic                  o_done;
    t_out                  o_out;

    int fail_count;
    int pending;
    int beats_checked;
    int cycles        = 0;
    int items_sent    = 0;
    int settings_used = 1;
    int op_tally [8]  = '{default: 0};

    always #10 i_clk = ~i_clk;

    text_mode_terminal_engine_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tmte_screen_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_in            (i_in),
        .i_done          (o_done),
        .i_out           (o_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // A hung engine or a lost result beat ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[text_mode_terminal_engine_unit] ERROR");
            $finish;
        end
    end

    // Every command starts from random bits, so the fields that an operation
    // ignores still carry noise on every bit.
    function automatic t_in noisy_cmd(logic [2:0] op);
        t_in cmd;
        cmd    = t_in'($urandom);
        cmd.op = op;
        return cmd;
    endfunction

    function automatic t_in read_cmd(logic [4:0] row, logic [6:0] col);
        t_in cmd;
        cmd          = noisy_cmd(OP_READ);
        cmd.read_row = row;
        cmd.read_col = col;
        return cmd;
    endfunction

    function automatic t_in put_cmd(logic [7:0] ch);
        t_in cmd;
        cmd           = noisy_cmd(OP_PUT);
        cmd.char_code = ch;
        return cmd;
    endfunction

    // Mostly printable text; now and then any byte, newline included.
    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
    endfunction

    // Start is raised together with the beat and held until the engine takes
    // it. Busy is sampled on the falling edge, where it is stable, so the
    // rising edge that follows is known to be the accepting one.
    task automatic send_cmd(t_in cmd);
        logic was_busy;
        i_start <= 1'b1;
        i_in    <= cmd;
        do begin
            @(negedge i_clk);
            was_busy = o_busy;
            @(posedge i_clk);
        end while (was_busy);
        op_tally[cmd.op]++;
    endtask

    // Hold start low until every outstanding result beat has come back.
    task automatic drain();
        i_start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    // Drives one register write for one edge; the caller drops the write
    // enable after the last of a group of writes.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // One random command beat: random idle cycles first, and now and then a
    // full pause until the engine has answered everything.
    task automatic issue(t_in cmd, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        if ($urandom_range(0, 79) == 0) begin
            drain();
        end
        send_cmd(cmd);
        items_sent++;
    endtask

    // The random part is built from short sequences. Text lines are long
    // enough at times to hit the pending wrap, and newline bursts push the
    // cursor to the bottom row, where every further newline scrolls.
    task automatic run_random(int n_items, int idle_pct);
        int target;
        int kind;
        int len;
        target = items_sent + n_items;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom_range(COLUMNS-2, COLUMNS+6);
                end else begin
                    len = $urandom_range(0, 40);
                end
                repeat (len) issue(put_cmd(text_char()), idle_pct);
                if ($urandom_range(0, 4) != 0) begin
                    issue(put_cmd(NEWLINE_CODE), idle_pct);
                end
            end else if (kind < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
                repeat (len) issue(put_cmd(NEWLINE_CODE), idle_pct);
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 6)) issue(noisy_cmd(OP_BACKSPACE), idle_pct);
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 6) == 0) begin
                        issue(read_cmd(5'($urandom), 7'($urandom)), idle_pct);
                    end else begin
                        issue(read_cmd(5'($urandom_range(0, ROWS-1)),
                                       7'($urandom_range(0, COLUMNS-1))), idle_pct);
                    end
                end
            end else if (kind < 90) begin
                issue(noisy_cmd(OP_CLR_LINE), idle_pct);
            end else if (kind < 91) begin
                issue(noisy_cmd(OP_CLR_ALL), idle_pct);
            end else if (kind < 94) begin
                issue(noisy_cmd(3'($urandom_range(int'(OP_READ) + 1, 7))), idle_pct);
            end else begin
                issue(t_in'($urandom), idle_pct);
            end
        end
    endtask

    initial begin
        int idle_plan [PHASES];
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] blank;

        idle_plan = '{0, 67, 12, 0, 67, 12};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run with the reset register values. The first
        // command waits out the clearing pass through busy.
        send_cmd(put_cmd(CHAR_A));
        send_cmd(put_cmd(8'h00));
        send_cmd(put_cmd(8'hFF));
        send_cmd(put_cmd(NEWLINE_CODE));
        // From the start of row one this walks back over the blank rest of
        // row zero and erases the last character written there.
        send_cmd(noisy_cmd(OP_BACKSPACE));
        send_cmd(read_cmd(5'd0, 7'd0));
        send_cmd(read_cmd(5'd0, 7'd2));
        send_cmd(read_cmd(5'(ROWS-1), 7'(COLUMNS-1)));
        send_cmd(read_cmd(5'(ROWS), 7'd0));
        send_cmd(read_cmd(5'd0, 7'(COLUMNS)));
        send_cmd(read_cmd(5'h1F, 7'h7F));
        send_cmd(noisy_cmd(OP_CLR_LINE));
        // Backspace at the origin must leave everything alone.
        send_cmd(noisy_cmd(OP_BACKSPACE));
        // A space in the reset attribute equals the reset blank value, so
        // the backspace after it treats the cell as blank and stops at the
        // origin.
        send_cmd(put_cmd(CHAR_SPACE));
        send_cmd(noisy_cmd(OP_BACKSPACE));
        for (int op = int'(OP_READ) + 1; op < 8; op++) begin
            send_cmd(noisy_cmd(3'(op)));
        end
        send_cmd(put_cmd(CHAR_X));
        send_cmd(noisy_cmd(OP_CLR_ALL));
        send_cmd(read_cmd(5'd0, 7'd0));
        items_sent = 21;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // Registers change only while the engine has nothing left.
                drain();
                case (p)
                    1: begin attr = 8'hFF; blank = 16'h0000; end
                    2: begin attr = 8'h00; blank = 16'hFFFF; end
                    // Spaces typed in this phase count as blank cells.
                    3: begin attr = 8'($urandom); blank = {attr, CHAR_SPACE}; end
                    4: begin attr = ATTR_RESET; blank = BLANK_RESET; end
                    default: begin attr = 8'($urandom); blank = 16'($urandom); end
                endcase
                write_reg(CFG_TEXT_ATTR, CFG_DATA_W'(attr));
                write_reg(CFG_BLANK_CELL, blank);
                i_cfg_we <= 1'b0;
                settings_used++;
            end
            run_random(ITEMS_PER_PHASE, idle_plan[p]);
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d commands: %0d put, %0d backspace, %0d clear line,",
                 items_sent, op_tally[OP_PUT], op_tally[OP_BACKSPACE],
                 op_tally[OP_CLR_LINE]);
        $display("%0d clear screen, %0d read, %0d unused codes; %0d beats compared under %0d register settings.",
                 op_tally[OP_CLR_ALL], op_tally[OP_READ],
                 op_tally[5] + op_tally[6] + op_tally[7], beats_checked, settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("[text_mode_terminal_engine_unit] OK");
        end else begin
            $display("[text_mode_terminal_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
